FILE: sv/tapc_pkg.sv
// Shared widths and datapath types for the triangle area prefix-sum core.
package tapc_pkg;

  localparam int POS_W  = 24;
  localparam int IDX_W  = 12;
  localparam int VTX_W  = 3 * POS_W;
  localparam int EDGE_W = POS_W + 1;
  localparam int MOP_W  = 27;
  localparam int PROD_W = 2 * MOP_W;
  localparam int K_W    = 51;
  localparam int KL_W   = 26;
  localparam int KH_W   = K_W - KL_W;
  localparam int ROOT_W = 51;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int AREA_W = 49;
  localparam int SUM_W  = 63;

  localparam int IX = 0;
  localparam int IY = 1;
  localparam int IZ = 2;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [EDGE_W-1:0] edge_t;
  typedef logic signed [MOP_W-1:0]  mop_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [K_W-1:0]    kval_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic [ROOT_W-1:0]        root_t;
  typedef logic [VTX_W-1:0]         vtx_t;

endpackage

FILE: sv/tapc_vstore.sv
// Vertex position memory with one write port and one registered read port.
module tapc_vstore #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  tapc_pkg::vtx_t      wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output tapc_pkg::vtx_t      rd_data
);

  tapc_pkg::vtx_t mem [DEPTH];
  tapc_pkg::vtx_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/tapc_mul.sv
// Shared signed multiplier with a registered product.
module tapc_mul (
  input  logic            clk,
  input  tapc_pkg::mop_t  op_a,
  input  tapc_pkg::mop_t  op_b,
  output tapc_pkg::prod_t prod
);

  tapc_pkg::prod_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

FILE: sv/tapc_isqrt.sv
// Bit-serial restoring integer square root, one root bit per cycle.
module tapc_isqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  tapc_pkg::sq_t   radicand,
  output logic            done,
  output tapc_pkg::root_t root
);

  localparam int RW = tapc_pkg::ROOT_W + 3;
  localparam int CW = $clog2(tapc_pkg::ROOT_W);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  tapc_pkg::sq_t   rad_r;
  logic [RW-1:0]   rem_r;
  tapc_pkg::root_t root_r;

  logic [RW-1:0]   cand;
  logic [RW-1:0]   trial;
  logic            ge;

  assign cand  = {rem_r[RW-3:0], rad_r[tapc_pkg::SQ_W-1 -: 2]};
  assign trial = RW'({root_r, 2'b01});
  assign ge    = (cand >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(tapc_pkg::ROOT_W - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[tapc_pkg::SQ_W-3:0], 2'b00};
      rem_r  <= ge ? (cand - trial) : cand;
      root_r <= {root_r[tapc_pkg::ROOT_W-2:0], ge};
      cnt_r  <= cnt_r + CW'(1);
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: sv/triangle_area_prefix_sum_core.sv
// Top level: vertex store, sequencer for cross products, squares, root and running sum.
// A vertex-write beat is written to the store at acceptance if its address is below VERTEX_DEPTH.
// A triangle beat keeps the core busy through vertex fetch, cross product, squaring,
// the bit-serial square root and loading the result, plus any output stall.
// No new beat of either kind is accepted until the result is loaded into the output register.
// Synchronous active-low reset clears the sequencer, output valid and running sum.
module triangle_area_prefix_sum_core #(
  parameter int VERTEX_DEPTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic [tapc_pkg::IDX_W-1:0]         in_vertex_addr,
  input  logic signed [tapc_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [tapc_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [tapc_pkg::POS_W-1:0]  in_pos_z,
  input  logic [tapc_pkg::IDX_W-1:0]         in_corner_a,
  input  logic [tapc_pkg::IDX_W-1:0]         in_corner_b,
  input  logic [tapc_pkg::IDX_W-1:0]         in_corner_c,
  input  logic                               in_last_triangle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tapc_pkg::AREA_W-1:0]        out_tri_area,
  output logic [tapc_pkg::SUM_W-1:0]         out_area_sum,
  output logic                               out_sum_last
);

  localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam logic [16:0] DEPTH_V = 17'(VERTEX_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FETCH  = 6'b000010,
    S_CROSS  = 6'b000100,
    S_SQUARE = 6'b001000,
    S_ROOT   = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  logic [tapc_pkg::IDX_W-1:0] corner_r [3];
  logic                       last_r;
  tapc_pkg::pos_t             a_r [3];
  tapc_pkg::edge_t            e1_r [3];
  tapc_pkg::edge_t            e2_r [3];
  tapc_pkg::kval_t            k_r [3];
  tapc_pkg::sq_t              sq_r;
  logic                       rd_oob_r;
  logic [tapc_pkg::SUM_W-1:0] run_r;

  logic                       out_valid_r;
  logic [tapc_pkg::AREA_W-1:0] out_area_r;
  logic [tapc_pkg::SUM_W-1:0] out_sum_r;
  logic                       out_last_r;

  logic                       in_fire;
  logic                       wr_en;
  logic                       rd_en;
  logic [tapc_pkg::IDX_W-1:0] rd_idx;
  tapc_pkg::vtx_t             rd_data;
  tapc_pkg::vtx_t             vtx;
  tapc_pkg::pos_t             vx, vy, vz;
  tapc_pkg::mop_t             op_a, op_b;
  tapc_pkg::prod_t            prod;
  logic [tapc_pkg::KL_W-1:0]  kl [3];
  logic [tapc_pkg::KH_W-1:0]  kh [3];
  logic                       sqrt_start;
  logic                       sqrt_done;
  tapc_pkg::root_t            root;
  logic [tapc_pkg::AREA_W-1:0] area;
  logic [tapc_pkg::SUM_W:0]   sum_full;
  logic [tapc_pkg::SUM_W-1:0] sum_sat;
  logic                       out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = in_fire && !in_req_type && ({5'b0, in_vertex_addr} < DEPTH_V);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    rd_idx = corner_r[0];
      2'd1:    rd_idx = corner_r[1];
      default: rd_idx = corner_r[2];
    endcase
  end
  assign rd_en = (state_r == S_FETCH) && (cnt_r < 4'd3);

  tapc_vstore #(
    .DEPTH (VERTEX_DEPTH),
    .AW    (AW)
  ) u_vstore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_vertex_addr)),
    .wr_data ({in_pos_x, in_pos_y, in_pos_z}),
    .rd_en   (rd_en),
    .rd_addr (AW'(rd_idx)),
    .rd_data (rd_data)
  );

  assign vtx = rd_oob_r ? '0 : rd_data;
  assign vx  = $signed(vtx[3*tapc_pkg::POS_W-1 -: tapc_pkg::POS_W]);
  assign vy  = $signed(vtx[2*tapc_pkg::POS_W-1 -: tapc_pkg::POS_W]);
  assign vz  = $signed(vtx[tapc_pkg::POS_W-1:0]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kl[i] = k_r[i][tapc_pkg::KL_W-1:0];
      kh[i] = k_r[i][tapc_pkg::K_W-1:tapc_pkg::KL_W];
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == S_CROSS) begin
      case (cnt_r)
        4'd0: begin op_a = tapc_pkg::mop_t'(e1_r[tapc_pkg::IY]);
                    op_b = tapc_pkg::mop_t'(e2_r[tapc_pkg::IZ]); end
        4'd1: begin op_a = tapc_pkg::mop_t'(e1_r[tapc_pkg::IZ]);
                    op_b = tapc_pkg::mop_t'(e2_r[tapc_pkg::IY]); end
        4'd2: begin op_a = tapc_pkg::mop_t'(e1_r[tapc_pkg::IZ]);
                    op_b = tapc_pkg::mop_t'(e2_r[tapc_pkg::IX]); end
        4'd3: begin op_a = tapc_pkg::mop_t'(e1_r[tapc_pkg::IX]);
                    op_b = tapc_pkg::mop_t'(e2_r[tapc_pkg::IZ]); end
        4'd4: begin op_a = tapc_pkg::mop_t'(e1_r[tapc_pkg::IX]);
                    op_b = tapc_pkg::mop_t'(e2_r[tapc_pkg::IY]); end
        4'd5: begin op_a = tapc_pkg::mop_t'(e1_r[tapc_pkg::IY]);
                    op_b = tapc_pkg::mop_t'(e2_r[tapc_pkg::IX]); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end else if (state_r == S_SQUARE) begin
      case (cnt_r)
        4'd0: begin op_a = $signed({1'b0, kl[0]}); op_b = $signed({1'b0, kl[0]}); end
        4'd1: begin op_a = tapc_pkg::mop_t'($signed(kh[0]));
                    op_b = $signed({1'b0, kl[0]}); end
        4'd2: begin op_a = tapc_pkg::mop_t'($signed(kh[0]));
                    op_b = tapc_pkg::mop_t'($signed(kh[0])); end
        4'd3: begin op_a = $signed({1'b0, kl[1]}); op_b = $signed({1'b0, kl[1]}); end
        4'd4: begin op_a = tapc_pkg::mop_t'($signed(kh[1]));
                    op_b = $signed({1'b0, kl[1]}); end
        4'd5: begin op_a = tapc_pkg::mop_t'($signed(kh[1]));
                    op_b = tapc_pkg::mop_t'($signed(kh[1])); end
        4'd6: begin op_a = $signed({1'b0, kl[2]}); op_b = $signed({1'b0, kl[2]}); end
        4'd7: begin op_a = tapc_pkg::mop_t'($signed(kh[2]));
                    op_b = $signed({1'b0, kl[2]}); end
        4'd8: begin op_a = tapc_pkg::mop_t'($signed(kh[2]));
                    op_b = tapc_pkg::mop_t'($signed(kh[2])); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  tapc_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign sqrt_start = (state_r == S_ROOT) && (cnt_r == 4'd0);

  tapc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sq_r),
    .done     (sqrt_done),
    .root     (root)
  );

  assign area     = root[tapc_pkg::AREA_W:1];
  assign sum_full = {1'b0, run_r} + (tapc_pkg::SUM_W + 1)'(area);
  assign sum_sat  = sum_full[tapc_pkg::SUM_W] ? '1 : sum_full[tapc_pkg::SUM_W-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 4'd1;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_fire && in_req_type) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        if (cnt_r == 4'd3) begin
          state_nxt = S_CROSS;
          cnt_nxt   = '0;
        end
      end
      S_CROSS: begin
        if (cnt_r == 4'd6) begin
          state_nxt = S_SQUARE;
          cnt_nxt   = '0;
        end
      end
      S_SQUARE: begin
        if (cnt_r == 4'd9) begin
          state_nxt = S_ROOT;
          cnt_nxt   = '0;
        end
      end
      S_ROOT: begin
        cnt_nxt = 4'd1;
        if (sqrt_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cnt_nxt = '0;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      run_r       <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        run_r       <= last_r ? '0 : sum_sat;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_req_type) begin
      corner_r[0] <= in_corner_a;
      corner_r[1] <= in_corner_b;
      corner_r[2] <= in_corner_c;
      last_r      <= in_last_triangle;
    end

    if (rd_en) begin
      rd_oob_r <= ({5'b0, rd_idx} >= DEPTH_V);
    end

    if (state_r == S_FETCH) begin
      case (cnt_r)
        4'd1: begin
          a_r[tapc_pkg::IX] <= vx;
          a_r[tapc_pkg::IY] <= vy;
          a_r[tapc_pkg::IZ] <= vz;
        end
        4'd2: begin
          e1_r[tapc_pkg::IX] <= tapc_pkg::edge_t'(vx) - tapc_pkg::edge_t'(a_r[tapc_pkg::IX]);
          e1_r[tapc_pkg::IY] <= tapc_pkg::edge_t'(vy) - tapc_pkg::edge_t'(a_r[tapc_pkg::IY]);
          e1_r[tapc_pkg::IZ] <= tapc_pkg::edge_t'(vz) - tapc_pkg::edge_t'(a_r[tapc_pkg::IZ]);
        end
        4'd3: begin
          e2_r[tapc_pkg::IX] <= tapc_pkg::edge_t'(vx) - tapc_pkg::edge_t'(a_r[tapc_pkg::IX]);
          e2_r[tapc_pkg::IY] <= tapc_pkg::edge_t'(vy) - tapc_pkg::edge_t'(a_r[tapc_pkg::IY]);
          e2_r[tapc_pkg::IZ] <= tapc_pkg::edge_t'(vz) - tapc_pkg::edge_t'(a_r[tapc_pkg::IZ]);
        end
        default: begin
        end
      endcase
    end

    if (state_r == S_CROSS) begin
      case (cnt_r)
        4'd1: k_r[0] <= tapc_pkg::kval_t'(prod);
        4'd2: k_r[0] <= k_r[0] - tapc_pkg::kval_t'(prod);
        4'd3: k_r[1] <= tapc_pkg::kval_t'(prod);
        4'd4: k_r[1] <= k_r[1] - tapc_pkg::kval_t'(prod);
        4'd5: k_r[2] <= tapc_pkg::kval_t'(prod);
        4'd6: k_r[2] <= k_r[2] - tapc_pkg::kval_t'(prod);
        default: begin
        end
      endcase
      sq_r <= '0;
    end

    if (state_r == S_SQUARE) begin
      case (cnt_r)
        4'd1, 4'd4, 4'd7: sq_r <= sq_r + tapc_pkg::sq_t'(prod);
        4'd2, 4'd5, 4'd8: sq_r <= sq_r + (tapc_pkg::sq_t'(prod) << (tapc_pkg::KL_W + 1));
        4'd3, 4'd6, 4'd9: sq_r <= sq_r + (tapc_pkg::sq_t'(prod) << (2 * tapc_pkg::KL_W));
        default: begin
        end
      endcase
    end

    if ((state_r == S_OUT) && out_free) begin
      out_area_r <= area;
      out_sum_r  <= sum_sat;
      out_last_r <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tri_area = out_area_r;
  assign out_area_sum = out_sum_r;
  assign out_sum_last = out_last_r;

endmodule
